[hw/rtl/msdco_pkg.sv]
// ----------------------------------------------------------------------------
// msdco_pkg
// shared types and constants of the multi-server dispatcher
// ----------------------------------------------------------------------------
`default_nettype none

package msdco_pkg;

  localparam int CFG_W  = 5;
  localparam int JOB_W  = 24;
  localparam int DUR_W  = 16;
  localparam int TIME_W = 32;

  localparam logic [CFG_W-1:0] NUM_SERVERS_RST = 5'd4;

  typedef struct packed {
    logic [TIME_W-1:0] finish;
    logic [JOB_W-1:0]  job;
  } srv_entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/msdco_srv_ram.sv]
// ----------------------------------------------------------------------------
// msdco_srv_ram
// server table: finish time and job id per server, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module msdco_srv_ram #(
  parameter int MAX_SERVERS = 16,
  localparam int AW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [AW-1:0]            waddr,
  input  msdco_pkg::srv_entry_t   wdata,
  input  wire [AW-1:0]            raddr,
  output msdco_pkg::srv_entry_t   rdata
);
  import msdco_pkg::*;

  srv_entry_t mem [MAX_SERVERS];
  srv_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[hw/rtl/msdco_grp_stack.sv]
// ----------------------------------------------------------------------------
// msdco_grp_stack
// stack of job ids that complete at one shared time
// ----------------------------------------------------------------------------
`default_nettype none

module msdco_grp_stack #(
  parameter int MAX_SERVERS = 16,
  localparam int AW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1,
  localparam int UW = $clog2(MAX_SERVERS + 1)
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  msdco_pkg::stk_ctrl_t         ctrl,
  input  wire [msdco_pkg::JOB_W-1:0]   push_job,
  output logic [UW-1:0]                cnt,
  output logic [msdco_pkg::JOB_W-1:0]  rd_job
);
  import msdco_pkg::*;

  logic [JOB_W-1:0] mem [MAX_SERVERS];
  logic [UW-1:0]    cnt_r;
  logic [UW-1:0]    top_idx;
  logic [JOB_W-1:0] rd_job_r;

  assign top_idx = cnt_r - UW'(1);

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[cnt_r[AW-1:0]] <= push_job;
    end
    if (ctrl.pop) begin
      rd_job_r <= mem[top_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctrl.push) begin
      cnt_r <= cnt_r + UW'(1);
    end else if (ctrl.pop) begin
      cnt_r <= top_idx;
    end
  end

  assign cnt    = cnt_r;
  assign rd_job = rd_job_r;

endmodule

`default_nettype wire

[hw/rtl/msdco_min_unit.sv]
// ----------------------------------------------------------------------------
// msdco_min_unit
// shared compare unit: keeps the earliest finishing server seen in a scan
// ----------------------------------------------------------------------------
`default_nettype none

module msdco_min_unit #(
  parameter int MAX_SERVERS = 16,
  localparam int AW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     clr,
  input  wire                     cand_vld,
  input  wire [AW-1:0]            cand_idx,
  input  msdco_pkg::srv_entry_t   cand,
  output logic [AW-1:0]           best_idx,
  output msdco_pkg::srv_entry_t   best
);
  import msdco_pkg::*;

  logic       best_vld_r;
  logic [AW-1:0] best_idx_r;
  srv_entry_t best_r;
  logic       take;

  // strict less keeps the lower server on ties
  assign take = cand_vld && (!best_vld_r || (cand.finish < best_r.finish));

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      best_vld_r <= 1'b0;
    end else if (take) begin
      best_vld_r <= 1'b1;
    end
    if (take) begin
      best_idx_r <= cand_idx;
      best_r     <= cand;
    end
  end

  assign best_idx = best_idx_r;
  assign best     = best_r;

endmodule

`default_nettype wire

[hw/rtl/multi_server_dispatch_completion_order.sv]
// ----------------------------------------------------------------------------
// multi_server_dispatch_completion_order
// k-server earliest-free dispatcher with completion ordering
// ----------------------------------------------------------------------------
// A job that opens an unused server is written straight into the server
// table from idle and gives no word. Any other job scans the servers in use
// through the one compare unit, one table read a cycle, then drains the
// completion stack when the earliest finish time differs from the stacked
// one or the stack is full. A flush repeats that scan once per busy server
// and drains what is left on the stack at the end. The block takes
// no new word until every word of the current one has been handed to the
// output register; a full output register stalls the drain.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_server_dispatch_completion_order #(
  parameter int MAX_SERVERS = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_wen,
  input  wire  [4:0]  cfg_wdata,      // num_servers
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [39:0] in_tdata,       // job_id, duration
  input  wire         in_tuser,       // func
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [55:0] out_tdata,      // done_job_id, finish_time
  output logic        out_tlast
);
  import msdco_pkg::*;

  localparam int AW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int UW = $clog2(MAX_SERVERS + 1);
  localparam int CW = (UW > CFG_W) ? UW : CFG_W;

  typedef enum logic [3:0] {
    IDLE, SCAN, CJ, PUSH, FL_NEXT, DR_POP, DR_EMIT, FL_END, FINISH
  } state_t;

  state_t state_r;

  logic [CFG_W-1:0]     ns_r;
  logic                 flushing_r;
  logic [JOB_W-1:0]     in_job_r;
  logic [DUR_W-1:0]     in_dur_r;
  logic [UW-1:0]        used_r;
  logic [UW-1:0]        left_r;
  logic [UW-1:0]        iss_r;
  logic                 rd_pend_r;
  logic [AW-1:0]        rd_idx_r;
  logic [MAX_SERVERS-1:0] taken_r;
  logic [TIME_W-1:0]    gtime_r;
  logic                 drain_end_r;
  logic                 pend_vld_r;
  logic [JOB_W-1:0]     pend_job_r;
  logic [TIME_W-1:0]    pend_time_r;
  logic                 out_tvalid_r;
  logic [JOB_W-1:0]     out_job_r;
  logic [TIME_W-1:0]    out_time_r;
  logic                 out_last_r;

  logic                 in_acc;
  logic [CW-1:0]        k_eff;
  logic                 room;
  logic                 out_free;
  logic                 emit_ok;
  logic                 out_load;
  logic                 need_drain;
  logic [TIME_W:0]      sum;
  logic [TIME_W-1:0]    sat_time;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  srv_entry_t           ram_wdata;
  srv_entry_t           ram_rdata;
  logic                 min_clr;
  logic                 cand_vld;
  logic [AW-1:0]        best_idx;
  srv_entry_t           best;
  stk_ctrl_t            stk_ctrl;
  logic [UW-1:0]        stk_cnt;
  logic [JOB_W-1:0]     stk_job;

  assign in_tready = (state_r == IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign emit_ok   = !pend_vld_r || out_free;
  assign out_load  = pend_vld_r && out_free &&
                     ((state_r == DR_EMIT) || (state_r == FINISH));

  always_comb begin
    if (ns_r == '0) begin
      k_eff = CW'(1);
    end else if (CW'(ns_r) > CW'(MAX_SERVERS)) begin
      k_eff = CW'(MAX_SERVERS);
    end else begin
      k_eff = CW'(ns_r);
    end
  end

  assign room       = CW'(used_r) < k_eff;
  assign sum        = {1'b0, best.finish} + {{(TIME_W + 1 - DUR_W){1'b0}}, in_dur_r};
  assign sat_time   = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  assign need_drain = (stk_cnt != '0) &&
                      ((best.finish != gtime_r) || (stk_cnt >= UW'(MAX_SERVERS)));
  assign cand_vld   = (state_r == SCAN) && rd_pend_r && !taken_r[rd_idx_r];

  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = best_idx;
    ram_wdata    = '{finish: sat_time, job: in_job_r};
    min_clr      = 1'b0;
    stk_ctrl     = '{push: 1'b0, pop: 1'b0};
    unique case (state_r)
      IDLE: begin
        if (in_acc && !in_tuser) begin
          if (room) begin
            ram_we    = 1'b1;
            ram_waddr = used_r[AW-1:0];
            ram_wdata = '{finish: {{(TIME_W - DUR_W){1'b0}}, in_tdata[39:24]},
                          job: in_tdata[23:0]};
          end else begin
            min_clr = 1'b1;
          end
        end
      end
      CJ:      ram_we = !flushing_r;
      PUSH:    stk_ctrl.push = 1'b1;
      FL_NEXT: min_clr = (left_r != '0);
      DR_POP:  stk_ctrl.pop = (stk_cnt != '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= IDLE;
      ns_r         <= NUM_SERVERS_RST;
      used_r       <= '0;
      taken_r      <= '0;
      gtime_r      <= '0;
      pend_vld_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
      rd_pend_r    <= 1'b0;
      flushing_r   <= 1'b0;
      drain_end_r  <= 1'b0;
      iss_r        <= '0;
      left_r       <= '0;
    end else begin
      if (cfg_wen) begin
        ns_r <= cfg_wdata;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        IDLE: begin
          if (in_acc) begin
            in_job_r   <= in_tdata[23:0];
            in_dur_r   <= in_tdata[39:24];
            flushing_r <= in_tuser;
            iss_r      <= '0;
            rd_pend_r  <= 1'b0;
            if (in_tuser) begin
              left_r  <= used_r;
              state_r <= FL_NEXT;
            end else if (room) begin
              used_r <= used_r + UW'(1);
            end else begin
              state_r <= SCAN;
            end
          end
        end
        SCAN: begin
          rd_pend_r <= (iss_r < used_r);
          rd_idx_r  <= iss_r[AW-1:0];
          if (iss_r < used_r) begin
            iss_r <= iss_r + UW'(1);
          end else if (!rd_pend_r) begin
            state_r <= CJ;
          end
        end
        CJ: begin
          if (flushing_r) begin
            taken_r[best_idx] <= 1'b1;
          end
          if (need_drain) begin
            drain_end_r <= 1'b0;
            state_r     <= DR_POP;
          end else begin
            state_r <= PUSH;
          end
        end
        PUSH: begin
          gtime_r <= best.finish;
          state_r <= flushing_r ? FL_NEXT : FINISH;
        end
        FL_NEXT: begin
          if (left_r == '0) begin
            drain_end_r <= 1'b1;
            state_r     <= DR_POP;
          end else begin
            left_r    <= left_r - UW'(1);
            iss_r     <= '0;
            rd_pend_r <= 1'b0;
            state_r   <= SCAN;
          end
        end
        DR_POP: begin
          if (stk_cnt != '0) begin
            state_r <= DR_EMIT;
          end else if (drain_end_r) begin
            state_r <= FL_END;
          end else begin
            state_r <= PUSH;
          end
        end
        DR_EMIT: begin
          if (emit_ok) begin
            if (pend_vld_r) begin
              out_job_r    <= pend_job_r;
              out_time_r   <= pend_time_r;
              out_last_r   <= 1'b0;
            end
            pend_vld_r  <= 1'b1;
            pend_job_r  <= stk_job;
            pend_time_r <= gtime_r;
            state_r     <= DR_POP;
          end
        end
        FL_END: begin
          used_r  <= '0;
          gtime_r <= '0;
          taken_r <= '0;
          state_r <= FINISH;
        end
        FINISH: begin
          if (!pend_vld_r) begin
            state_r <= IDLE;
          end else if (out_free) begin
            out_job_r    <= pend_job_r;
            out_time_r   <= pend_time_r;
            out_last_r   <= 1'b1;
            pend_vld_r   <= 1'b0;
            state_r      <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_time_r, out_job_r};
  assign out_tlast  = out_last_r;

  msdco_srv_ram #(
    .MAX_SERVERS (MAX_SERVERS)
  ) u_srv_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (iss_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  msdco_min_unit #(
    .MAX_SERVERS (MAX_SERVERS)
  ) u_min_unit (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (min_clr),
    .cand_vld (cand_vld),
    .cand_idx (rd_idx_r),
    .cand     (ram_rdata),
    .best_idx (best_idx),
    .best     (best)
  );

  msdco_grp_stack #(
    .MAX_SERVERS (MAX_SERVERS)
  ) u_grp_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (stk_ctrl),
    .push_job (best.job),
    .cnt      (stk_cnt),
    .rd_job   (stk_job)
  );

`ifndef SYNTHESIS
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == IDLE) |-> (!pend_vld_r && (taken_r == '0)))
    else $error("pending word or taken mask left at idle");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stk_cnt <= UW'(MAX_SERVERS))
    else $error("completion stack overflow");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(MAX_SERVERS))
    else $error("servers in use beyond table depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    stk_ctrl.push |-> (stk_cnt < UW'(MAX_SERVERS)))
    else $error("push into full completion stack");
`endif

endmodule

`default_nettype wire

[tb/sv/tb_multi_server_dispatch_completion_order.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_server_dispatch_completion_order
// self-checking bench for the k-server earliest-free dispatcher
// ----------------------------------------------------------------------------
// Jobs and flushes go in on the input stream. A behavioral scheduler in the
// bench tracks every server's finish time, the tie stack and the server count
// register, and queues the completions that each accepted word must produce.
// The output monitor checks job id, finish time and tlast against that queue
// in order. Directed tests cover the basic dispatch, ties, zero durations and
// a full tie stack. Random phases then sweep the server count, including
// out-of-range values, under several flow-control patterns on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_multi_server_dispatch_completion_order;
  import msdco_pkg::*;

  localparam int NSRV = 16;
  localparam int SETTLE_CYCLES = 40;
  localparam int PRINT_CAP = 50;

  typedef enum logic {
    FN_ARRIVE = 1'b0,
    FN_FLUSH  = 1'b1
  } func_t;

  typedef struct {
    logic [JOB_W-1:0]  job;
    logic [TIME_W-1:0] ftime;
    logic              last;
  } completion_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_wen;
  logic [CFG_W-1:0]  cfg_wdata;
  logic              in_tvalid;
  wire               in_tready;
  logic [39:0]       in_tdata;   // job_id, duration
  logic              in_tuser;   // func
  wire               out_tvalid;
  logic              out_tready;
  wire  [55:0]       out_tdata;  // done_job_id, finish_time
  wire               out_tlast;

  // scheduler state
  logic [TIME_W-1:0] srv_finish [NSRV];
  logic [JOB_W-1:0]  srv_job    [NSRV];
  int                srv_used;
  logic [JOB_W-1:0]  tie_stack  [NSRV];
  logic [TIME_W-1:0] tie_time;
  int                tie_count;
  logic [CFG_W-1:0]  servers_cfg;

  completion_t       completions_due[$];
  completion_t       batch[$];
  int                mismatch_count;
  int                send_idle_pct;
  int                recv_stall_pct;

  multi_server_dispatch_completion_order #(
    .MAX_SERVERS(NSRV)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- scheduler

  function automatic void emit_ties();
    completion_t c;
    while (tie_count > 0) begin
      tie_count--;
      c = '{job: tie_stack[tie_count], ftime: tie_time, last: 1'b0};
      batch.insert(batch.size(), c);
    end
  endfunction

  function automatic void retire_job(input logic [TIME_W-1:0] t,
                                     input logic [JOB_W-1:0] job);
    if (tie_count > 0 && (t != tie_time || tie_count >= NSRV)) begin
      emit_ties();
    end
    tie_stack[tie_count] = job;
    tie_count++;
    tie_time = t;
  endfunction

  function automatic int earliest_server(input logic [NSRV-1:0] taken);
    int best;
    best = -1;
    for (int i = 0; i < srv_used; i++) begin
      if (taken[i]) continue;
      if (best < 0 || srv_finish[i] < srv_finish[best]) best = i;
    end
    return best;
  endfunction

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [DUR_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + (TIME_W + 1)'(b);
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  function automatic void predict_dispatch(input func_t fn,
                                           input logic [JOB_W-1:0] job,
                                           input logic [DUR_W-1:0] dur);
    int k;
    int m;
    logic [NSRV-1:0] taken;
    batch.delete();
    if (fn == FN_ARRIVE) begin
      k = int'(servers_cfg);
      if (k < 1) k = 1;
      if (k > NSRV) k = NSRV;
      if (srv_used < k) begin
        srv_finish[srv_used] = TIME_W'(dur);
        srv_job[srv_used] = job;
        srv_used++;
      end else begin
        m = earliest_server('0);
        if (m >= 0) begin
          retire_job(srv_finish[m], srv_job[m]);
          srv_finish[m] = sat_add(srv_finish[m], dur);
          srv_job[m] = job;
        end
      end
    end else begin
      taken = '0;
      for (int left = srv_used; left > 0; left--) begin
        m = earliest_server(taken);
        if (m < 0) break;
        taken[m] = 1'b1;
        retire_job(srv_finish[m], srv_job[m]);
      end
      emit_ties();
      srv_used = 0;
      tie_time = '0;
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) completions_due.insert(completions_due.size(), batch[i]);
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) $display("%0t: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : out_monitor
    completion_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (completions_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word job=%h time=%h",
                                  out_tdata[JOB_W-1:0], out_tdata[55:JOB_W]));
      end else begin
        want = completions_due.pop_front();
        if (out_tdata[JOB_W-1:0] !== want.job)
          report_mismatch($sformatf("job id %h, want %h",
                                    out_tdata[JOB_W-1:0], want.job));
        if (out_tdata[JOB_W+TIME_W-1:JOB_W] !== want.ftime)
          report_mismatch($sformatf("finish time %h, want %h",
                                    out_tdata[JOB_W+TIME_W-1:JOB_W], want.ftime));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("tlast %b, want %b", out_tlast, want.last));
      end
    end
  end

  // ---------------------------------------------------------------- driving

  task automatic push_word(input func_t fn, input logic [JOB_W-1:0] job,
                           input logic [DUR_W-1:0] dur);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= fn;
    in_tdata <= {dur, job};
    do @(posedge clk); while (!in_tready);
    predict_dispatch(fn, job, dur);
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (completions_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_servers(input logic [CFG_W-1:0] value);
    settle();
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen <= 1'b0;
    servers_cfg = value;
  endtask

  task automatic set_pressure(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // ---------------------------------------------------------------- tests

  // four servers from reset: field extremes, ties, zero duration, empty flush
  task automatic test_basic_dispatch();
    set_pressure(0, 0);
    push_word(FN_ARRIVE, 24'h000000, 16'h0001);
    push_word(FN_ARRIVE, 24'hFFFFFF, 16'hFFFF);
    push_word(FN_ARRIVE, 24'h000001, 16'h0003);
    push_word(FN_ARRIVE, 24'h000002, 16'h0001);
    push_word(FN_ARRIVE, 24'h00000A, 16'h0000);
    push_word(FN_ARRIVE, 24'h00000B, 16'h0002);
    push_word(FN_ARRIVE, 24'h00000C, 16'h0005);
    push_word(FN_ARRIVE, 24'h00000D, 16'h0001);
    push_word(FN_FLUSH, 24'hFFFFFF, 16'hFFFF);
    push_word(FN_FLUSH, 24'h000000, 16'h0000);
    push_word(FN_ARRIVE, 24'h123456, 16'h8000);
    push_word(FN_FLUSH, 24'h000000, 16'h0000);
  endtask

  // sixteen servers tied on one time fill the tie stack during flush, forcing a full-stack drain
  task automatic test_full_stack();
    write_servers(5'd16);
    set_pressure(0, 37);
    for (int i = 0; i < NSRV; i++) push_word(FN_ARRIVE, JOB_W'(24'h000100 + i), 16'd5);
    push_word(FN_ARRIVE, 24'hABCDEF, 16'd0);
    push_word(FN_FLUSH, JOB_W'($urandom), DUR_W'($urandom));
  endtask

  task automatic random_stream(input int count);
    int pick;
    logic [DUR_W-1:0] dur;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(9);
      case (pick)
        0:       dur = '0;
        1, 2, 3: dur = DUR_W'($urandom_range(1, 8));
        4, 5, 6: dur = DUR_W'($urandom_range(1, 300));
        default: dur = DUR_W'($urandom);
      endcase
      if ($urandom_range(99) < 7) begin
        push_word(FN_FLUSH, JOB_W'($urandom), DUR_W'($urandom));
      end else begin
        push_word(FN_ARRIVE, JOB_W'($urandom), dur);
      end
    end
  endtask

  // server count sweep, kept state between phases lets the count drop below use
  task automatic test_random_phases();
    int cfg_list [8] = '{1, 16, 0, 31, 7, 2, 12, 4};
    for (int p = 0; p < 8; p++) begin
      write_servers(CFG_W'(cfg_list[p]));
      case (p % 4)
        0: set_pressure(0, 0);
        1: set_pressure(87, 0);
        2: set_pressure(0, 87);
        default: set_pressure(37, 37);
      endcase
      random_stream(40);
      if ($urandom_range(1)) push_word(FN_FLUSH, JOB_W'($urandom), DUR_W'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    srv_used = 0;
    tie_time = '0;
    tie_count = 0;
    servers_cfg = NUM_SERVERS_RST;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_basic_dispatch();
    test_full_stack();
    test_random_phases();
    settle();

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
